// ===== hdl/pfc_pkg.sv =====
package pfc_pkg;

    // Widths of the pixel payload and of the configuration channel.
    localparam int PIXEL_W    = 32;
    localparam int FORMAT_W   = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 3;

    // Register indexes on the configuration channel.
    localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DIRECTION    = 2'd1;

    // Target formats.
    typedef enum logic [FORMAT_W-1:0] {
        FMT_BGRA1555    = 3'd0,
        FMT_RGB565      = 3'd1,
        FMT_BGRA4444    = 3'd2,
        FMT_BGRA8888    = 3'd3,
        FMT_BGR0888     = 3'd4,
        FMT_BGR888      = 3'd5,
        FMT_RGB888      = 3'd6,
        FMT_UNSUPPORTED = 3'd7
    } pixel_format_t;

    // Conversion direction.
    localparam logic DIR_PACK   = 1'b0;
    localparam logic DIR_UNPACK = 1'b1;

endpackage

// ===== hdl/pfc_if.sv =====
interface pfc_pixel_in_if;
    import pfc_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_in;
    logic               last_pixel;

    modport source (output valid, output pixel_in, output last_pixel, input ready);
    modport sink   (input valid, input pixel_in, input last_pixel, output ready);
endinterface

interface pfc_pixel_out_if;
    import pfc_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_out;
    logic               last_out;
    logic               format_error;

    modport source (output valid, output pixel_out, output last_out, output format_error,
                    input ready);
    modport sink   (input valid, input pixel_out, input last_out, input format_error,
                    output ready);
endinterface

interface pfc_cfg_if;
    import pfc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/pixel_format_converter.sv =====
// A request accepted on src is captured in the input register, then moves
// into the result register, which presents it on dst, once that is free.
// Throughput: one pixel per clock while dst takes results; the input register
// and the result register form a two-stage pipeline that advances whenever
// the result register is free.
// Reset (rst_n, asynchronous, active low) empties both stages and sets the
// format to BGRA1555 and the direction to pack.
module pixel_format_converter (
    input  logic             clk,
    input  logic             rst_n,
    pfc_cfg_if.sink          cfg,
    pfc_pixel_in_if.sink     src,
    pfc_pixel_out_if.source  dst
);
    import pfc_pkg::*;

    // Configuration registers. Writes are always taken; an index beyond the
    // two registers is simply dropped.
    pixel_format_t            format_reg;
    logic                     direction_reg;

    // Stage one: the captured input pixel.
    logic                     in_valid_reg;
    logic [PIXEL_W-1:0]       in_pixel_reg;
    logic                     in_last_reg;

    // Stage two: the converted result as presented on dst.
    logic                     out_valid_reg;
    logic [PIXEL_W-1:0]       out_pixel_reg;
    logic                     out_last_reg;
    logic                     out_error_reg;

    logic                     out_free;
    logic                     in_advance;
    logic                     in_load;
    logic [PIXEL_W-1:0]       conv_pixel_next;
    logic                     conv_error_next;
    logic [15:0]              half;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg    <= FMT_BGRA1555;
            direction_reg <= DIR_PACK;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_PIXEL_FORMAT)
            begin
                format_reg <= pixel_format_t'(cfg.data[FORMAT_W-1:0]);
            end
            else if (cfg.index == REG_DIRECTION)
            begin
                direction_reg <= cfg.data[0];
            end
        end
    end

    // The result register is free when it is empty or its pixel is being
    // taken this cycle. Stage one moves forward into it under that condition,
    // and stage one takes a new request when it is empty or moving forward,
    // so a full pipeline keeps flowing at one pixel per clock while dst.ready is high.
    assign out_free   = !out_valid_reg || dst.ready;
    assign in_advance = in_valid_reg && out_free;
    assign src.ready  = !in_valid_reg || out_free;
    assign in_load    = src.valid && src.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (src.ready)
        begin
            in_valid_reg <= src.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_pixel_reg <= src.pixel_in;
            in_last_reg  <= src.last_pixel;
        end
    end

    // The conversion itself is pure wiring of bit fields chosen by the format
    // and direction. Sixteen-bit formats only look at the low half-word when
    // unpacking; RGB565 widens each component by repeating its top bits.
    assign half = in_pixel_reg[15:0];

    always_comb
    begin
        conv_pixel_next = '0;
        conv_error_next = 1'b0;
        case (format_reg)
            FMT_BGRA1555:
            begin
                if (direction_reg == DIR_UNPACK)
                    conv_pixel_next = {16'h0000, half[14:0], half[15]};
                else
                    conv_pixel_next = {16'h0000, in_pixel_reg[31], in_pixel_reg[7:3],
                                       in_pixel_reg[15:11], in_pixel_reg[23:19]};
            end
            FMT_RGB565:
            begin
                if (direction_reg == DIR_UNPACK)
                    conv_pixel_next = {8'h00,
                                       half[4:0], half[4:2],
                                       half[10:5], half[10:9],
                                       half[15:11], half[15:13]};
                else
                    conv_pixel_next = {16'h0000, in_pixel_reg[7:3],
                                       in_pixel_reg[15:10], in_pixel_reg[23:19]};
            end
            FMT_BGRA4444:
            begin
                if (direction_reg == DIR_UNPACK)
                    conv_pixel_next = {16'h0000, half[11:0], half[15:12]};
                else
                    conv_pixel_next = {16'h0000, in_pixel_reg[31:28], in_pixel_reg[7:4],
                                       in_pixel_reg[15:12], in_pixel_reg[23:20]};
            end
            FMT_BGRA8888:
            begin
                // Red and blue trade places; the swap is its own inverse.
                conv_pixel_next = {in_pixel_reg[31:24], in_pixel_reg[7:0],
                                   in_pixel_reg[15:8], in_pixel_reg[23:16]};
            end
            FMT_BGR0888, FMT_BGR888:
            begin
                conv_pixel_next = {8'h00, in_pixel_reg[7:0],
                                   in_pixel_reg[15:8], in_pixel_reg[23:16]};
            end
            FMT_RGB888:
            begin
                conv_pixel_next = {8'h00, in_pixel_reg[23:0]};
            end
            default:
            begin
                // No conversion defined: flag it and return zero.
                conv_error_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance)
        begin
            out_pixel_reg <= conv_pixel_next;
            out_last_reg  <= in_last_reg;
            out_error_reg <= conv_error_next;
        end
    end

    assign dst.valid        = out_valid_reg;
    assign dst.pixel_out    = out_pixel_reg;
    assign dst.last_out     = out_last_reg;
    assign dst.format_error = out_error_reg;

endmodule

// ===== bench/tb_pixel_format_converter.sv =====
`timescale 1ns / 1ps

module tb_pixel_format_converter;
    import pfc_pkg::*;

    // Number of consecutive cycles in which no request moves on any channel
    // before the run is declared hung. The longest quiet stretch of a correct
    // run is the deliberate receiver hold-off plus one gap on each side, so
    // this leaves a wide margin.
    localparam int QUIET_LIMIT = 2000;

    // Length of the long receiver hold-off used to fill the pipeline.
    localparam int LONG_HOLD_CYCLES = 300;

    // The block is two stages deep, so a few cycles past the last result
    // are enough to be sure that nothing else is on its way.
    localparam int SETTLE_CYCLES = 4;

    // Register indexes that the block has no register behind.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

    // One converted pixel as it leaves the block.
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_out;
        logic               last_out;
        logic               format_error;
    } pixel_result_t;

    logic clk;
    logic rst_n;

    pfc_cfg_if       cfg_bus ();
    pfc_pixel_in_if  src_bus ();
    pfc_pixel_out_if dst_bus ();

    pixel_format_converter dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .src   (src_bus),
        .dst   (dst_bus)
    );

    // Our own copy of the two registers, updated whenever a register write
    // request is accepted. Reset values match the block's reset.
    pixel_format_t cur_format = FMT_BGRA1555;
    logic          cur_dir    = DIR_PACK;

    // Converted pixels that the block still owes us, oldest first.
    pixel_result_t pending_pixels[$];

    int mismatch_count    = 0;
    bit src_no_idle       = 1'b0;
    bit sink_no_idle      = 1'b0;
    int sink_hold_cycles  = 0;

    // Clock: 8 ns period.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Predicts what the block produces for one pixel under a given setting.
    // Packing truncates RGBA32 components into the target layout; unpacking
    // rotates the 1555/4444 words, widens RGB565 by replicating the top
    // bits of each component, and swaps red and blue in the BGR byte formats.
    function automatic pixel_result_t convert_pixel(input logic [PIXEL_W-1:0] v,
                                                    input logic last,
                                                    input pixel_format_t fmt,
                                                    input logic dir);
        pixel_result_t r;
        logic [15:0]   h;
        h              = v[15:0];
        r.last_out     = last;
        r.format_error = 1'b0;
        case (fmt)
            FMT_BGRA1555:
                if (dir == DIR_PACK)
                    r.pixel_out = {16'h0, v[31], v[7:3], v[15:11], v[23:19]};
                else
                    r.pixel_out = {16'h0, h[14:0], h[15]};
            FMT_RGB565:
                if (dir == DIR_PACK)
                    r.pixel_out = {16'h0, v[7:3], v[15:10], v[23:19]};
                else
                    // Alpha byte is zero; each component gets its own top
                    // bits copied below it.
                    r.pixel_out = {8'h0, h[4:0], h[4:2], h[10:5], h[10:9],
                                   h[15:11], h[15:13]};
            FMT_BGRA4444:
                if (dir == DIR_PACK)
                    r.pixel_out = {16'h0, v[31:28], v[7:4], v[15:12], v[23:20]};
                else
                    r.pixel_out = {16'h0, h[11:0], h[15:12]};
            FMT_BGRA8888:
                r.pixel_out = {v[31:24], v[7:0], v[15:8], v[23:16]};
            FMT_BGR0888, FMT_BGR888:
                r.pixel_out = {8'h0, v[7:0], v[15:8], v[23:16]};
            FMT_RGB888:
                r.pixel_out = {8'h0, v[23:0]};
            default:
            begin
                r.pixel_out    = '0;
                r.format_error = 1'b1;
            end
        endcase
        return r;
    endfunction

    // Writes one register through the configuration channel and mirrors the
    // write in our copy once the request is accepted.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        if (index == REG_PIXEL_FORMAT)
            cur_format = pixel_format_t'(data[FORMAT_W-1:0]);
        else if (index == REG_DIRECTION)
            cur_dir = data[0];
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Offers one pixel after a random gap and waits until it is accepted.
    // valid stays high on return so back-to-back pixels need no bubble.
    task automatic send_pixel(input logic [PIXEL_W-1:0] pixel, input logic last);
        int gap;
        gap = src_no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            @(negedge clk);
            src_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        src_bus.valid      <= 1'b1;
        src_bus.pixel_in   <= pixel;
        src_bus.last_pixel <= last;
        do
            @(posedge clk);
        while (!src_bus.ready);
        pending_pixels.push_back(convert_pixel(pixel, last, cur_format, cur_dir));
    endtask

    // Stops offering pixels and waits until every owed result is back and
    // the pipeline has had time to empty.
    task automatic wait_pipeline_empty();
        @(negedge clk);
        src_bus.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Registers are only written while the block is idle.
    task automatic apply_setting(input pixel_format_t fmt, input logic dir);
        wait_pipeline_empty();
        write_reg(REG_PIXEL_FORMAT, fmt);
        write_reg(REG_DIRECTION, {{(CFG_DATA_W-1){1'b0}}, dir});
    endtask

    task automatic check_field(input string name, input logic [PIXEL_W-1:0] expected,
                               input logic [PIXEL_W-1:0] actual);
        if (expected !== actual)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", name, expected, actual);
            mismatch_count++;
        end
    endtask

    // The block must come out of reset packing into BGRA1555.
    task automatic test_reset_defaults();
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h0000_0000, 1'b1);
        send_pixel(32'h8055_AA7F, 1'b0);
    endtask

    // Every format in both directions, with all input bits set so that each
    // truncation, rotation and high-bit mask is visible.
    task automatic test_every_setting();
        for (int f = 0; f < 8; f++)
        begin
            for (int d = 0; d < 2; d++)
            begin
                apply_setting(pixel_format_t'(f[FORMAT_W-1:0]), d[0]);
                send_pixel(32'hFFFF_FFFF, f[0] ^ d[0]);
            end
        end
    endtask

    task automatic test_special_cases();
        // Unpacking a 16-bit format must ignore the upper half entirely.
        apply_setting(FMT_RGB565, DIR_UNPACK);
        send_pixel(32'hFFFF_0000, 1'b0);
        // RGB565 widening with distinct bit patterns per component; the
        // alpha byte of the result stays zero.
        send_pixel(32'h0000_A5A5, 1'b1);
        // Unpacking a 24-bit format must ignore the top byte.
        apply_setting(FMT_RGB888, DIR_UNPACK);
        send_pixel(32'hFF00_0000, 1'b0);
        // BGR0888 drops alpha in both directions.
        apply_setting(FMT_BGR0888, DIR_PACK);
        send_pixel(32'hFF00_0000, 1'b1);
        apply_setting(FMT_BGR0888, DIR_UNPACK);
        send_pixel(32'hFF12_3456, 1'b0);
        // An unsupported format flags an error and zeroes the pixel but
        // still carries the end-of-image mark through.
        apply_setting(FMT_UNSUPPORTED, DIR_PACK);
        send_pixel(32'hDEAD_BEEF, 1'b1);
    endtask

    // Register writes are masked to their width, and writes to indexes with
    // no register behind them must leave the setting alone.
    task automatic test_register_writes();
        apply_setting(FMT_BGRA4444, DIR_UNPACK);
        write_reg(REG_DIRECTION, 3'b110);
        send_pixel(32'h1234_5678, 1'b0);
        wait_pipeline_empty();
        write_reg(REG_SPARE_2, 3'b111);
        write_reg(REG_SPARE_3, 3'b101);
        send_pixel(32'h8765_4321, 1'b1);
        wait_pipeline_empty();
        write_reg(REG_DIRECTION, 3'b111);
        write_reg(REG_SPARE_3, 3'b010);
        send_pixel(32'hCAFE_F00D, 1'b0);
    endtask

    // The receiver stops for a long stretch while the sender keeps offering
    // pixels back to back, so both stages fill and src.ready must drop.
    // Nothing may be lost or duplicated when the receiver resumes.
    task automatic test_backpressure();
        apply_setting(FMT_BGRA8888, DIR_PACK);
        src_no_idle      = 1'b1;
        sink_hold_cycles = LONG_HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
            send_pixel($urandom, 1'($urandom_range(0, 1)));
        src_no_idle = 1'b0;
    endtask

    // Random pixels under a series of settings. The first and last phases
    // pin the lowest and highest register values; every fourth phase runs
    // with no idling on either side.
    task automatic test_random_traffic();
        pixel_format_t fmt;
        logic          dir;
        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase == 0)
            begin
                fmt = FMT_BGRA1555;
                dir = DIR_PACK;
            end
            else if (phase == 11)
            begin
                fmt = FMT_UNSUPPORTED;
                dir = DIR_UNPACK;
            end
            else
            begin
                fmt = pixel_format_t'(3'($urandom_range(0, 7)));
                dir = 1'($urandom_range(0, 1));
            end
            apply_setting(fmt, dir);
            src_no_idle  = (phase % 4 == 2);
            sink_no_idle = (phase % 4 == 2);
            for (int i = 0; i < 75; i++)
                send_pixel($urandom, $urandom_range(0, 7) == 0);
        end
        src_no_idle  = 1'b0;
        sink_no_idle = 1'b0;
    endtask

    // Main sequence: all inputs known from time zero, a single reset, then
    // the tests in turn and the final verdict.
    initial
    begin
        rst_n              = 1'b0;
        src_bus.valid      = 1'b0;
        src_bus.pixel_in   = '0;
        src_bus.last_pixel = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = REG_PIXEL_FORMAT;
        cfg_bus.data       = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_every_setting();
        test_special_cases();
        test_register_writes();
        test_backpressure();
        test_random_traffic();

        wait_pipeline_empty();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Result receiver: before each result, stalls for a random number of
    // cycles (the long hold-off when one is requested, none in no-idle
    // phases), then takes the result and compares it with the oldest prediction.
    initial
    begin : result_sink
        int            stall;
        pixel_result_t want;
        dst_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (sink_hold_cycles > 0)
            begin
                stall            = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            else if (sink_no_idle)
                stall = 0;
            else
                stall = $urandom_range(0, 19);
            if (stall > 0)
            begin
                @(negedge clk);
                dst_bus.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            dst_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!dst_bus.valid);
            if (pending_pixels.size() == 0)
            begin
                $error("result 0x%08h arrived with no request outstanding",
                       dst_bus.pixel_out);
                mismatch_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("pixel_out", want.pixel_out, dst_bus.pixel_out);
                check_field("last_out", 32'(want.last_out), 32'(dst_bus.last_out));
                check_field("format_error", 32'(want.format_error),
                            32'(dst_bus.format_error));
            end
        end
    end

    // Watchdog: ends the run if no request moves on any channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (src_bus.valid && src_bus.ready) ||
                (dst_bus.valid && dst_bus.ready) || (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule

// ===== pixel_format_converter.f =====
hdl/pfc_pkg.sv
hdl/pfc_if.sv
hdl/pixel_format_converter.sv
bench/tb_pixel_format_converter.sv
